@@ sv/roe_pkg.sv @@
// ----------------------------------------------------------------------------
// roe_pkg
// Shared constants, stage payload types and per-stage step functions of the
// Roe-average face pipeline.
// ----------------------------------------------------------------------------
package roe_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WEIGHT_SHIFT = 29;
  localparam int unsigned SQ_STEPS = 32;   // root bits per square root
  localparam int unsigned DIV_STEPS = 32;  // quotient bits per division
  localparam logic [WORD_BITS-2:0] HMAX = '1;

  // square root iteration: remainder and partial root
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  // restoring division iteration: partial remainder and quotient
  typedef struct packed {
    logic [65:0] rem;
    logic [31:0] q;
  } dv_t;

  // first iterative section: three roots and two side divisions
  typedef struct packed {
    sq_t [2:0]             sq;    // density root, center weight, neighbor weight
    dv_t [1:0]             dv;    // pressure term per side
    logic [1:0][31:0]      dd;    // divisor 2*rho per side
    logic [1:0]            sat;
    logic [1:0]            zero;
    logic [1:0][46:0]      t2;    // kinetic term per side
    logic [1:0][2:0][31:0] vel;
  } sb_t;

  // second iterative section: three velocity means and the enthalpy mean
  typedef struct packed {
    dv_t [3:0]   dv;
    logic [31:0] d;
    logic        zden;
    logic [30:0] dens;
  } sc_t;

  function automatic sq_t sq_step(sq_t s, int unsigned k);
    logic [63:0] b;
    logic [63:0] t;
    sq_t o;
    b = 64'd1 << (62 - 2 * k);
    t = s.r + b;
    if (s.v >= t) begin
      o.v = s.v - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic dv_t div_step(dv_t s, logic [31:0] d, int unsigned i);
    logic [65:0] sh;
    dv_t o;
    sh = {34'd0, d} << i;
    o = s;
    if (s.rem >= sh) begin
      o.rem = s.rem - sh;
      o.q = s.q | (32'd1 << i);
    end
    return o;
  endfunction

  function automatic sb_t b_step(sb_t s, int unsigned k);
    sb_t o;
    o = s;
    for (int j = 0; j < 3; j++) o.sq[j] = sq_step(s.sq[j], k);
    for (int j = 0; j < 2; j++) o.dv[j] = div_step(s.dv[j], s.dd[j], DIV_STEPS - 1 - k);
    return o;
  endfunction

  function automatic sc_t c_step(sc_t s, int unsigned k);
    sc_t o;
    o = s;
    for (int j = 0; j < 4; j++) o.dv[j] = div_step(s.dv[j], s.d, DIV_STEPS - 1 - k);
    return o;
  endfunction

  function automatic logic [31:0] mag(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

@@ sv/roe_average_interface_state.sv @@
// ----------------------------------------------------------------------------
// roe_average_interface_state
// Roe-averaged density, velocity and total enthalpy across one cell face.
// ----------------------------------------------------------------------------
// Accepts one face request per clock while req_stall is low and returns one
// result per request, in order. The pipeline is 72 register stages deep; its
// depth is set by two chains of 32 one-bit iterations: the first takes the
// density root, the two square-root density weights and the pressure terms;
// the second divides the weighted sums for the three velocities and the
// enthalpy. All values are Q16.16; densities of zero drop out, and both
// densities zero give all-zero mean fields. The whole pipeline holds while a
// finished result is stalled at the output, and req_stall follows that hold.
module roe_average_interface_state (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [30:0]        rho_center,
  input  logic signed [31:0] vel_x_center,
  input  logic signed [31:0] vel_y_center,
  input  logic signed [31:0] vel_z_center,
  input  logic [30:0]        press_center,
  input  logic [30:0]        rho_neighbor,
  input  logic signed [31:0] vel_x_neighbor,
  input  logic signed [31:0] vel_y_neighbor,
  input  logic signed [31:0] vel_z_neighbor,
  input  logic [30:0]        press_neighbor,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [30:0]        roe_density,
  output logic signed [31:0] roe_vel_x,
  output logic signed [31:0] roe_vel_y,
  output logic signed [31:0] roe_vel_z,
  output logic signed [31:0] roe_enthalpy
);
  import roe_pkg::*;

  // global advance: hold everything while the output is full and stalled
  logic adv;
  assign adv = !(res_valid && res_stall);
  assign req_stall = !adv;

  // stage 0: registered request (index 0 is the center, 1 the neighbor)
  logic                  v0;
  logic [1:0][30:0]      s0_rho;
  logic [1:0][30:0]      s0_press;
  logic [1:0][2:0][31:0] s0_vel;

  // stage 1: products
  logic                  v1;
  logic [61:0]           s1_prod;
  logic [1:0][2:0][63:0] s1_sq;
  logic [1:0][49:0]      s1_num;
  logic [1:0][31:0]      s1_dd;
  logic [1:0]            s1_zero;
  logic [1:0][30:0]      s1_rho;
  logic [1:0][2:0][31:0] s1_vel;

  // first iterative section
  logic [SQ_STEPS:0] vb;
  sb_t               sb [SQ_STEPS+1];
  sb_t               sb_next;

  // stage 3: side enthalpies, weights, denominator
  logic                  v3;
  logic [1:0][30:0]      s3_h;
  logic [1:0][29:0]      s3_w;
  logic [30:0]           s3_den;
  logic                  s3_zden;
  logic [30:0]           s3_dens;
  logic [1:0][2:0][31:0] s3_vel;
  logic [1:0][30:0]      s3_h_next;
  logic [30:0]           s3_den_next;

  // stage 4: weighted products
  logic                  v4;
  logic [2:0][1:0][62:0] s4_pv;
  logic [1:0][60:0]      s4_ph;
  logic [2:0][1:0][62:0] s4_pv_next;
  logic [30:0]           s4_den;
  logic                  s4_zden;
  logic [30:0]           s4_dens;

  // stage 5: weighted sums
  logic             v5;
  logic [2:0][63:0] s5_sv;
  logic [61:0]      s5_sh;
  logic [2:0][63:0] s5_sv_next;
  logic [30:0]      s5_den;
  logic             s5_zden;
  logic [30:0]      s5_dens;

  // second iterative section
  logic [DIV_STEPS:0] vc;
  sc_t                sc [DIV_STEPS+1];
  sc_t                sc_next;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      vb <= '0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vc <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v0 <= req_valid;
      v1 <= v0;
      vb <= {vb[SQ_STEPS-1:0], v1};
      v3 <= vb[SQ_STEPS];
      v4 <= v3;
      v5 <= v4;
      vc <= {vc[DIV_STEPS-1:0], v5};
      res_valid <= vc[DIV_STEPS];
    end
  end

  // stage 0 and 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rho <= {rho_neighbor, rho_center};
      s0_press <= {press_neighbor, press_center};
      s0_vel[0] <= {vel_z_center, vel_y_center, vel_x_center};
      s0_vel[1] <= {vel_z_neighbor, vel_y_neighbor, vel_x_neighbor};

      s1_prod <= s0_rho[0] * s0_rho[1];
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          s1_sq[j][c] <= mag(s0_vel[j][c]) * mag(s0_vel[j][c]);
        end
        // 3.5 p scaled: (7 p) << FRAC_BITS over 2 rho
        s1_num[j] <= {({3'd0, s0_press[j]} << 3) - {3'd0, s0_press[j]}, {FRAC_BITS{1'b0}}};
        s1_dd[j] <= {s0_rho[j], 1'b0};
        s1_zero[j] <= (s0_rho[j] == 31'd0);
      end
      s1_rho <= s0_rho;
      s1_vel <= s0_vel;
    end
  end

  // load the first iterative section
  always_comb begin
    logic [63:0] ssum;
    sb_next = '0;
    sb_next.sq[0].v = {2'd0, s1_prod};
    sb_next.sq[1].v = {4'd0, s1_rho[0], 29'd0};
    sb_next.sq[2].v = {4'd0, s1_rho[1], 29'd0};
    for (int j = 0; j < 2; j++) begin
      ssum = s1_sq[j][0] + s1_sq[j][1] + s1_sq[j][2];
      sb_next.t2[j] = ssum[63:FRAC_BITS+1];
      sb_next.sat[j] = {14'd0, s1_num[j]} >= {1'b0, s1_dd[j], 31'd0};
      sb_next.dv[j].rem = {16'd0, s1_num[j]};
      sb_next.dd[j] = s1_dd[j];
    end
    sb_next.zero = s1_zero;
    sb_next.vel = s1_vel;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= sb_next;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sb[k+1] <= b_step(sb[k], k);
      end
    end
  end

  // stage 3: combine pressure and kinetic terms, saturate each side, zero a side whose density is zero
  always_comb begin
    logic [47:0] hsum;
    for (int j = 0; j < 2; j++) begin
      hsum = 48'(sb[SQ_STEPS].dv[j].q) + 48'(sb[SQ_STEPS].t2[j]);
      if (sb[SQ_STEPS].zero[j]) begin
        s3_h_next[j] = '0;
      end else if (sb[SQ_STEPS].sat[j] || hsum > 48'(HMAX)) begin
        s3_h_next[j] = HMAX;
      end else begin
        s3_h_next[j] = hsum[30:0];
      end
    end
    s3_den_next = 31'(sb[SQ_STEPS].sq[1].r[29:0]) + 31'(sb[SQ_STEPS].sq[2].r[29:0]);
  end

  // stage 4: weight times value
  always_comb begin
    logic signed [30:0] wa;
    logic signed [31:0] xb;
    logic signed [62:0] p;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 2; j++) begin
        wa = $signed({1'b0, s3_w[j]});
        xb = $signed(s3_vel[j][c]);
        p = wa * xb;
        s4_pv_next[c][j] = p;
      end
    end
  end

  // stage 5: sum both sides
  always_comb begin
    logic signed [63:0] a;
    for (int c = 0; c < 3; c++) begin
      a = $signed(s4_pv[c][0]) + $signed(s4_pv[c][1]);
      s5_sv_next[c] = a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_h <= s3_h_next;
      s3_w[0] <= sb[SQ_STEPS].sq[1].r[29:0];
      s3_w[1] <= sb[SQ_STEPS].sq[2].r[29:0];
      s3_den <= s3_den_next;
      s3_zden <= (s3_den_next == 31'd0);
      s3_dens <= sb[SQ_STEPS].sq[0].r[30:0];
      s3_vel <= sb[SQ_STEPS].vel;

      s4_pv <= s4_pv_next;
      for (int j = 0; j < 2; j++) begin
        s4_ph[j] <= s3_w[j] * s3_h[j];
      end
      s4_den <= s3_den;
      s4_zden <= s3_zden;
      s4_dens <= s3_dens;

      s5_sv <= s5_sv_next;
      s5_sh <= 62'(s4_ph[0]) + 62'(s4_ph[1]);
      s5_den <= s4_den;
      s5_zden <= s4_zden;
      s5_dens <= s4_dens;
    end
  end

  // load the second iterative section; bias velocity numerators by 2^31 * d
  // so the floor division runs unsigned
  always_comb begin
    logic signed [66:0] t;
    logic signed [66:0] dn;
    sc_next = '0;
    dn = 67'($signed({1'b0, s5_den}));
    for (int c = 0; c < 3; c++) begin
      t = (67'($signed(s5_sv[c])) <<< 1) + dn + (dn <<< 32);
      sc_next.dv[c].rem = t[65:0];
    end
    sc_next.dv[3].rem = {3'd0, s5_sh, 1'b0} + 66'(s5_den);
    sc_next.d = {s5_den, 1'b0};
    sc_next.zden = s5_zden;
    sc_next.dens = s5_dens;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc[0] <= sc_next;
      for (int k = 0; k < DIV_STEPS; k++) begin
        sc[k+1] <= c_step(sc[k], k);
      end
    end
  end

  // result register: remove the bias, zero the means when both densities are zero
  always_ff @(posedge clk) begin
    if (adv) begin
      roe_density <= sc[DIV_STEPS].dens;
      if (sc[DIV_STEPS].zden) begin
        roe_vel_x <= '0;
        roe_vel_y <= '0;
        roe_vel_z <= '0;
        roe_enthalpy <= '0;
      end else begin
        roe_vel_x <= $signed(sc[DIV_STEPS].dv[0].q ^ 32'h8000_0000);
        roe_vel_y <= $signed(sc[DIV_STEPS].dv[1].q ^ 32'h8000_0000);
        roe_vel_z <= $signed(sc[DIV_STEPS].dv[2].q ^ 32'h8000_0000);
        roe_enthalpy <= $signed(sc[DIV_STEPS].dv[3].q);
      end
    end
  end

  // mean enthalpy lies between two saturated non-negative side values
  a_enthalpy_nonneg: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !roe_enthalpy[31])
    else $error("negative mean enthalpy");

  // a finished item waiting behind a held output is not dropped
  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    (vc[DIV_STEPS] && req_stall) |=> vc[DIV_STEPS])
    else $error("item lost while output held");

endmodule
